[rtl/stc_pkg.sv]
// Shared types, codes and helper functions of the staircase tracker.
package stc_pkg;

   localparam int MAX_STAIRS = 8;
   localparam int IDX_W      = $clog2(MAX_STAIRS);
   localparam int CNT_W      = 4;
   localparam int LVL_W      = 24;
   localparam int TRIAL_W    = 10;
   localparam int REV_W      = 8;
   localparam int RND_W      = 8;
   localparam int MOD_CNT_W  = $clog2(RND_W + 1);
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
   localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

   localparam logic [CNT_W-1:0]          STAIR_COUNT_RST = CNT_W'(2);
   localparam logic [REV_W-1:0]          MAX_REV_RST     = REV_W'(6);
   localparam logic [TRIAL_W-1:0]        MAX_TRIALS_RST  = TRIAL_W'(100);
   localparam logic signed [LVL_W-1:0]   STEP_SIZE_RST   = LVL_W'(256);
   localparam logic signed [LVL_W-1:0]   START_LEVEL_RST = '0;

   typedef logic [IDX_W-1:0] stair_idx_type;

   typedef enum logic [1:0] {
      FUNC_ANSWER  = 2'd0,
      FUNC_START   = 2'd1,
      FUNC_RESTART = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STAIR_COUNT = 3'd0,
      CSR_MAX_REV     = 3'd1,
      CSR_MAX_TRIALS  = 3'd2,
      CSR_STEP_SIZE   = 3'd3,
      CSR_START_LEVEL = 3'd4
   } csr_idx_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_UPDATE = 5'b00010,
      S_WAIT   = 5'b00100,
      S_LEVEL  = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic signed [LVL_W-1:0] level;
      logic                    going_up;
      logic [TRIAL_W-1:0]      trials;
      logic [REV_W-1:0]        reversals;
   } stair_entry_type;

   typedef struct packed {
      logic            en;
      stair_idx_type   addr;
      stair_entry_type entry;
   } stair_wr_type;

   typedef struct packed {
      logic                    en;
      logic signed [LVL_W-1:0] level;
   } stair_clr_type;

   typedef struct packed {
      logic                    report_valid;
      logic [2:0]              report_stair;
      logic [TRIAL_W-1:0]      trial_number;
      logic signed [LVL_W-1:0] previous_level;
      logic                    answer_out;
      logic                    reversal;
      logic                    next_valid;
      logic [2:0]              next_stair;
      logic signed [LVL_W-1:0] next_level;
      logic                    all_finished;
   } result_type;

   // Clamp the programmed stair count to 1..MAX_STAIRS.
   function automatic logic [CNT_W-1:0] used_count(logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] n;
      n = count;
      if (n == '0) n = CNT_W'(1);
      if (n > CNT_W'(MAX_STAIRS)) n = CNT_W'(MAX_STAIRS);
      return n;
   endfunction

   function automatic logic every_done(logic [MAX_STAIRS-1:0] done, logic [CNT_W-1:0] n);
      logic r;
      r = 1'b1;
      for (int i = 0; i < MAX_STAIRS; i++) begin
         if (CNT_W'(i) < n && !done[i]) r = 1'b0;
      end
      return r;
   endfunction

   // First unfinished stair at or after start, wrapping at n.
   function automatic stair_idx_type pick_stair(logic [MAX_STAIRS-1:0] done,
                                                logic [CNT_W-1:0] n, stair_idx_type start);
      logic [CNT_W:0] pos;
      stair_idx_type  sel;
      logic           found;
      sel   = start;
      found = 1'b0;
      for (int k = 0; k < MAX_STAIRS; k++) begin
         pos = (CNT_W+1)'(start) + (CNT_W+1)'(k);
         if (pos >= (CNT_W+1)'(n)) pos = pos - (CNT_W+1)'(n);
         if (!found && (CNT_W+1)'(k) < (CNT_W+1)'(n) && !done[pos[IDX_W-1:0]]) begin
            sel   = pos[IDX_W-1:0];
            found = 1'b1;
         end
      end
      return sel;
   endfunction

endpackage

[rtl/stc_stair_mem.sv]
// Per-stair state memory with valid bits and a restart level snapshot.
module stc_stair_mem import stc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  stair_wr_type    wr,
   input  stair_clr_type   clr,
   input  stair_idx_type   rd_addr,
   output stair_entry_type rd_entry
);

   stair_entry_type         mem [MAX_STAIRS];
   logic [MAX_STAIRS-1:0]   valid_ff;
   logic [MAX_STAIRS-1:0]   valid_in;
   logic signed [LVL_W-1:0] snap_ff;
   logic signed [LVL_W-1:0] snap_in;
   stair_entry_type         rd_data_ff;
   logic                    rd_valid_ff;
   stair_entry_type         blank;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      snap_in  = snap_ff;
      if (clr.en) begin
         valid_in = '0;
         snap_in  = clr.level;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         snap_ff     <= START_LEVEL_RST;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         snap_ff     <= snap_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Unwritten entries read as a freshly restarted stair.
   always_comb begin
      blank       = '0;
      blank.level = snap_ff;
      rd_entry    = rd_valid_ff ? rd_data_ff : blank;
   end

endmodule

[rtl/stc_mod_unit.sv]
// Bit-serial remainder of the random pick by the stair count.
module stc_mod_unit import stc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RND_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output stair_idx_type    remainder
);

   logic                 busy_ff, busy_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   stair_idx_type        rem_ff, rem_in;
   logic [CNT_W-1:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, dvd_ff[RND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // Shift in one dividend bit, subtract when it fits.
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         rem_in = (rem_sh >= div_ff) ? IDX_W'(rem_sh - div_ff) : IDX_W'(rem_sh);
         cnt_in = cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(RND_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = !busy_ff;
   assign remainder = rem_ff;

endmodule

[rtl/interleaved_staircase_tracker_unit.sv]
// Top level of the interleaved one-up one-down staircase tracker.
//
// Usage: each request on the req_ channel (func in req_tuser, answer and
// random_pick in req_tdata) yields exactly one response on the rsp_ channel.
// An answer request updates the current stair and reports the trial, then
// picks the next unfinished stair; a start request only picks; a restart
// request reinitializes every stair to start_level. The user must write
// registers through csr_we/csr_index/csr_wdata only while no request is in
// flight; the block itself does not enforce it.
//
// Sequence: an answer or start request that picks a stair runs S_UPDATE,
// S_WAIT while the bit-serial remainder unit takes one bit of random_pick
// per cycle in eight steps, S_LEVEL for a registered read of the chosen
// stair's level, and S_EMIT; the answer that finishes the last stair skips
// S_LEVEL, and the other requests go from S_UPDATE to S_EMIT. One request
// is in flight at a time; req_tready rises together with rsp_tvalid.
// Reset: all stairs read as start level with cleared counters, current stair
// is 0, registers take their defaults, no response is pending.
// Stall: a held response waits in the output register; the next request is
// still accepted and its response waits until the register drains.
module interleaved_staircase_tracker_unit import stc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LVL_W-1:0]     csr_wdata,
   // requests
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // answer, random_pick, zero fill
   input  logic [1:0]           req_tuser,   // func
   // responses
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // report_stair, trial_number, previous_level,
                                             // answer_out, reversal, next_stair,
                                             // next_level, all_finished, zero fill
   output logic [1:0]           rsp_tuser    // report_valid, next_valid
);

   // configuration registers
   logic [CNT_W-1:0]        stair_count_ff;
   logic [REV_W-1:0]        max_rev_ff;
   logic [TRIAL_W-1:0]      max_trials_ff;
   logic signed [LVL_W-1:0] step_size_ff;
   logic signed [LVL_W-1:0] start_level_ff;

   // sequencer state
   state_type             state_ff, state_in;
   func_type              func_ff, func_in;
   logic                  ans_ff, ans_in;
   stair_idx_type         cur_ff, cur_in;
   logic [MAX_STAIRS-1:0] done_ff, done_in;
   result_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [CNT_W-1:0]      n_used;
   logic                  all_done;
   stair_idx_type         pick_idx;
   stair_idx_type         rd_addr;
   stair_entry_type       rd_entry;
   stair_wr_type          wr;
   stair_clr_type         clr;
   logic                  mod_done;
   stair_idx_type         mod_rem;

   // trial update datapath
   logic                    up;
   logic                    rev;
   logic [REV_W-1:0]        rev_cnt;
   logic [TRIAL_W-1:0]      trials_new;
   logic signed [LVL_W:0]   sum;
   logic signed [LVL_W-1:0] level_new;
   logic                    finished;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign n_used     = used_count(stair_count_ff);
   assign all_done   = every_done(done_ff, n_used);
   assign pick_idx   = pick_stair(done_ff, n_used, mod_rem);
   // Read the current stair, or the candidate while the pick resolves.
   assign rd_addr    = (state_ff == S_WAIT) ? pick_idx : cur_ff;

   stc_stair_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .clr      (clr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   stc_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_tdata[RND_W:1]),
      .divisor   (n_used),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // One-up one-down step of the current stair, with saturation.
   always_comb begin
      up         = !ans_ff;
      rev        = (rd_entry.trials != '0) && (rd_entry.going_up != up);
      rev_cnt    = (rev && rd_entry.reversals != '1) ? rd_entry.reversals + REV_W'(1)
                                                     : rd_entry.reversals;
      trials_new = (rd_entry.trials != '1) ? rd_entry.trials + TRIAL_W'(1)
                                           : rd_entry.trials;
      sum        = up ? ({rd_entry.level[LVL_W-1], rd_entry.level}
                         + {step_size_ff[LVL_W-1], step_size_ff})
                      : ({rd_entry.level[LVL_W-1], rd_entry.level}
                         - {step_size_ff[LVL_W-1], step_size_ff});
      if (sum[LVL_W] != sum[LVL_W-1]) begin
         level_new = sum[LVL_W] ? LVL_MIN : LVL_MAX;
      end else begin
         level_new = sum[LVL_W-1:0];
      end
      finished   = (trials_new >= max_trials_ff) || (rev_cnt >= max_rev_ff);
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      ans_in       = ans_ff;
      cur_in       = cur_ff;
      done_in      = done_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the held response once it is taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr           = '0;
      clr          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = func_type'(req_tuser);
               ans_in   = req_tdata[0];
               res_in   = '0;
               state_in = S_UPDATE;
            end
         end

         S_UPDATE: begin
            unique case (func_ff)
               FUNC_RESTART: begin
                  clr.en              = 1'b1;
                  clr.level           = start_level_ff;
                  done_in             = '0;
                  res_in.all_finished = 1'b0;
                  state_in            = S_EMIT;
               end
               FUNC_START: begin
                  if (all_done) begin
                     res_in.all_finished = 1'b1;
                     state_in            = S_EMIT;
                  end else begin
                     state_in = S_WAIT;
                  end
               end
               FUNC_ANSWER: begin
                  if (all_done) begin
                     res_in.all_finished = 1'b1;
                     state_in            = S_EMIT;
                  end else begin
                     // Report only a stair that is in use and still running.
                     if ((CNT_W'(cur_ff) < n_used) && !done_ff[cur_ff]) begin
                        wr.en                  = 1'b1;
                        wr.addr                = cur_ff;
                        wr.entry.level         = level_new;
                        wr.entry.going_up      = up;
                        wr.entry.trials        = trials_new;
                        wr.entry.reversals     = rev_cnt;
                        done_in[cur_ff]        = finished;
                        res_in.report_valid    = 1'b1;
                        res_in.report_stair    = 3'(cur_ff);
                        res_in.trial_number    = trials_new;
                        res_in.previous_level  = rd_entry.level;
                        res_in.answer_out      = ans_ff;
                        res_in.reversal        = rev;
                     end
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  res_in.all_finished = all_done;
                  state_in            = S_EMIT;
               end
            endcase
         end

         S_WAIT: begin
            if (mod_done) begin
               if (all_done) begin
                  res_in.all_finished = 1'b1;
                  state_in            = S_EMIT;
               end else begin
                  cur_in            = pick_idx;
                  res_in.next_valid = 1'b1;
                  res_in.next_stair = 3'(pick_idx);
                  state_in          = S_LEVEL;
               end
            end
         end

         S_LEVEL: begin
            res_in.next_level = rd_entry.level;
            state_in          = S_EMIT;
         end

         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cur_ff         <= '0;
         done_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         stair_count_ff <= STAIR_COUNT_RST;
         max_rev_ff     <= MAX_REV_RST;
         max_trials_ff  <= MAX_TRIALS_RST;
         step_size_ff   <= STEP_SIZE_RST;
         start_level_ff <= START_LEVEL_RST;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STAIR_COUNT: stair_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_MAX_REV:     max_rev_ff     <= csr_wdata[REV_W-1:0];
               CSR_MAX_TRIALS:  max_trials_ff  <= csr_wdata[TRIAL_W-1:0];
               CSR_STEP_SIZE:   step_size_ff   <= csr_wdata;
               CSR_START_LEVEL: start_level_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      func_ff     <= func_in;
      ans_ff      <= ans_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_data_ff.next_valid, rsp_data_ff.report_valid};
   assign rsp_tdata  = {5'b0,
                        rsp_data_ff.all_finished,
                        rsp_data_ff.next_level,
                        rsp_data_ff.next_stair,
                        rsp_data_ff.reversal,
                        rsp_data_ff.answer_out,
                        rsp_data_ff.previous_level,
                        rsp_data_ff.trial_number,
                        rsp_data_ff.report_stair};

endmodule

[rtl/stc_checker.sv]
// Port-level checks of the staircase tracker, bound to the top level.
module stc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[38:0] == 39'd0)
      else $error("report fields set without a report");

   a_next_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[65:39] == 27'd0)
      else $error("next fields set without a next trial");

   a_finished_no_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |-> !rsp_tuser[1] && rsp_tdata[71:67] == 5'd0)
      else $error("next trial given while all stairs finished");

endmodule

bind interleaved_staircase_tracker_unit stc_checker u_stc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
